>>> rtl/core/hgpe_pkg.sv
// Shared types and constants of the Henyey-Greenstein phase evaluator.
// No dependencies; imported by hgpe_chan, the top module and the testbench.
package hgpe_pkg;

    // Register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_G_RED   = 2'd0,
        REG_G_GREEN = 2'd1,
        REG_G_BLUE  = 2'd2
    } t_reg_idx;

    // round(2^25.5 / pi), output scale of the phase value
    localparam logic [23:0] K_HG   = 24'd15104801;
    // ceil(2^35 / 3): floor(x/3) = (x * RECIP3) >> 35 for x below 2^34
    localparam logic [33:0] RECIP3 = 34'd11453246123;
    localparam int          RECIP3_SHIFT = 35;

    localparam logic [30:0] N_ONE  = 31'd1 << 30;   // 1.0 in Q.30
    localparam logic [50:0] T_ONE  = 51'd1 << 45;   // 1.0 in Q.45
    localparam logic [31:0] SAT32  = 32'hFFFF_FFFF;

    // Pipeline depths
    localparam int SQRT_STAGES = 32;
    localparam int DIV1_STAGES = 64;
    localparam int DIV2_STAGES = 9;
    localparam int DIV3_STAGES = 24;
    localparam int CH_LAT  = 5 + SQRT_STAGES + DIV1_STAGES + DIV2_STAGES + DIV3_STAGES;
    localparam int TOP_LAT = 2 + CH_LAT + 3;

    typedef struct packed {
        logic n_zero;   // numerator is zero (g of exactly minus one)
        logic t_bad;    // base not positive
        logic q_sat;    // integer quotient too large, saturate
    } t_ch_flags;

    typedef struct packed {
        logic [30:0] n;
        logic [48:0] t;
        t_ch_flags   f;
    } t_sq_side;

    typedef struct packed {
        logic [31:0] s;
        t_ch_flags   f;
    } t_dv_side;

    typedef struct packed {
        logic [8:0] q;
        t_ch_flags  f;
    } t_fr_side;

endpackage

>>> rtl/core/hgpe_if.sv
// Valid/ready channel interfaces of the phase evaluator: direction pairs in,
// phase values out. Standalone, no package needed.
interface hgpe_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] v_x;
    logic signed [15:0] v_y;
    logic signed [15:0] v_z;
    logic signed [15:0] l_x;
    logic signed [15:0] l_y;
    logic signed [15:0] l_z;

    modport source(output valid, v_x, v_y, v_z, l_x, l_y, l_z, input ready);
    modport sink(input valid, v_x, v_y, v_z, l_x, l_y, l_z, output ready);
endinterface

interface hgpe_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] atten_red;
    logic [31:0] atten_green;
    logic [31:0] atten_blue;
    logic [31:0] pdf_value;
    logic        pdf_zero;

    modport source(output valid, atten_red, atten_green, atten_blue, pdf_value, pdf_zero,
                   input ready);
    modport sink(input valid, atten_red, atten_green, atten_blue, pdf_value, pdf_zero,
                 output ready);
endinterface

>>> rtl/core/hgpe_udiv.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; used three times per channel by hgpe_chan.
module hgpe_udiv #(
    parameter int NW = 8,   // quotient bits = stages
    parameter int DW = 8,   // divisor and remainder bits
    parameter int SW = 1    // sideband bits
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,   // initial partial remainder, below i_den
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);
    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_nq   [NW];   // remaining dividend bits, quotient shifted in
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];

    logic [DW-1:0] a_rem  [NW];
    logic [NW-1:0] a_nq   [NW];
    logic [DW-1:0] a_den  [NW];
    logic [SW-1:0] a_side [NW];
    logic [DW-1:0] n_rem  [NW];
    logic [NW-1:0] n_nq   [NW];

    always_comb begin
        a_rem[0]  = i_rem;
        a_nq[0]   = i_num;
        a_den[0]  = i_den;
        a_side[0] = i_side;
        for (int k = 1; k < NW; k++) begin
            a_rem[k]  = r_rem[k-1];
            a_nq[k]   = r_nq[k-1];
            a_den[k]  = r_den[k-1];
            a_side[k] = r_side[k-1];
        end
    end

    always_comb begin
        logic [DW:0] x;
        logic        ge;
        for (int k = 0; k < NW; k++) begin
            x  = {a_rem[k], a_nq[k][NW-1]};
            ge = (x >= {1'b0, a_den[k]});
            n_rem[k] = ge ? DW'(x - {1'b0, a_den[k]}) : x[DW-1:0];
            n_nq[k]  = {a_nq[k][NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_nq   <= n_nq;
            r_den  <= a_den;
            r_side <= a_side;
        end
    end

    assign o_quo  = r_nq[NW-1];
    assign o_rem  = r_rem[NW-1];
    assign o_side = r_side[NW-1];
endmodule

>>> rtl/core/hgpe_isqrt.sv
// Pipelined integer square root (floor), two radicand bits per stage.
// Standalone; used by hgpe_chan.
module hgpe_isqrt #(
    parameter int W  = 64,  // radicand bits, even
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [W-1:0]    i_rad,
    input  logic [SW-1:0]   i_side,
    output logic [W/2-1:0]  o_root,
    output logic [SW-1:0]   o_side
);
    localparam int HW = W / 2;
    localparam int RW = HW + 2;

    logic [RW-1:0] r_rem  [HW];
    logic [HW-1:0] r_root [HW];
    logic [W-1:0]  r_rad  [HW];
    logic [SW-1:0] r_side [HW];

    logic [RW-1:0] a_rem  [HW];
    logic [HW-1:0] a_root [HW];
    logic [W-1:0]  a_rad  [HW];
    logic [SW-1:0] a_side [HW];
    logic [RW-1:0] n_rem  [HW];
    logic [HW-1:0] n_root [HW];
    logic [W-1:0]  n_rad  [HW];

    always_comb begin
        a_rem[0]  = '0;
        a_root[0] = '0;
        a_rad[0]  = i_rad;
        a_side[0] = i_side;
        for (int k = 1; k < HW; k++) begin
            a_rem[k]  = r_rem[k-1];
            a_root[k] = r_root[k-1];
            a_rad[k]  = r_rad[k-1];
            a_side[k] = r_side[k-1];
        end
    end

    always_comb begin
        logic [RW-1:0] x;
        logic [RW-1:0] trial;
        logic          ge;
        for (int k = 0; k < HW; k++) begin
            x     = {a_rem[k][RW-3:0], a_rad[k][W-1:W-2]};
            trial = {a_root[k], 2'b01};
            ge    = (x >= trial);
            n_rem[k]  = ge ? (x - trial) : x;
            n_root[k] = {a_root[k][HW-2:0], ge};
            n_rad[k]  = {a_rad[k][W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_side <= a_side;
        end
    end

    assign o_root = r_root[HW-1];
    assign o_side = r_side[HW-1];
endmodule

>>> rtl/core/hgpe_chan.sv
// One color channel: Henyey-Greenstein value for asymmetry g and cosine c.
// Depends on hgpe_pkg, hgpe_isqrt and hgpe_udiv.
module hgpe_chan import hgpe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_g,
    input  logic signed [33:0] i_c,
    output logic [31:0]        o_val
);
    // g^2 and g*c
    logic signed [31:0] gg_full;
    logic signed [49:0] gc_full;
    logic [30:0]        r1_gg;
    logic [49:0]        r1_gc;

    assign gg_full = i_g * i_g;
    assign gc_full = 50'(i_g) * 50'(i_c);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_gg <= gg_full[30:0];
            r1_gc <= gc_full;
        end
    end

    // numerator, base and its special cases
    logic [50:0] t_sum;
    t_sq_side    n_sq;
    t_sq_side    r2_sq;

    assign t_sum = T_ONE + {5'b0, r1_gg, 15'b0} + {r1_gc, 1'b0};

    always_comb begin
        n_sq.n       = N_ONE - r1_gg;
        n_sq.f.n_zero = (r1_gg == N_ONE);
        n_sq.f.t_bad  = t_sum[50] || (t_sum == '0);
        n_sq.f.q_sat  = 1'b0;
        n_sq.t       = n_sq.f.t_bad ? 49'd1 : t_sum[48:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sq <= n_sq;
        end
    end

    // S = floor(sqrt(T * 2^14))
    logic [31:0] sq_root;
    t_sq_side    sq_side;

    hgpe_isqrt #(.W(64), .SW($bits(t_sq_side))) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  ({1'b0, r2_sq.t, 14'b0}),
        .i_side (r2_sq),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    // r = floor(N * 2^33 / T)
    logic [63:0] d1_quo;
    logic [48:0] d1_rem;
    t_dv_side    d1_in;
    t_dv_side    d1_side;

    assign d1_in.s = sq_root;
    assign d1_in.f = sq_side.f;

    hgpe_udiv #(.NW(DIV1_STAGES), .DW(49), .SW($bits(t_dv_side))) u_div_r (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rem  ('0),
        .i_num  ({sq_side.n, 33'b0}),
        .i_den  (sq_side.t),
        .i_side (d1_in),
        .o_quo  (d1_quo),
        .o_rem  (d1_rem),
        .o_side (d1_side)
    );

    // r / S: quotient of 512 or more saturates; else start from r[63:9]
    logic        q_big;
    logic [31:0] r3_rem0;
    logic [8:0]  r3_lo;
    t_dv_side    r3_side;

    assign q_big = (d1_quo[63:9] >= {23'b0, d1_side.s});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_rem0         <= q_big ? '0 : d1_quo[40:9];
            r3_lo           <= d1_quo[8:0];
            r3_side.s       <= d1_side.s;
            r3_side.f.n_zero <= d1_side.f.n_zero;
            r3_side.f.t_bad  <= d1_side.f.t_bad;
            r3_side.f.q_sat  <= q_big;
        end
    end

    logic [8:0]  d2_quo;
    logic [31:0] d2_rem;
    t_dv_side    d2_side;

    hgpe_udiv #(.NW(DIV2_STAGES), .DW(32), .SW($bits(t_dv_side))) u_div_q (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rem  (r3_rem0),
        .i_num  (r3_lo),
        .i_den  (r3_side.s),
        .i_side (r3_side),
        .o_quo  (d2_quo),
        .o_rem  (d2_rem),
        .o_side (d2_side)
    );

    // m * K, then floor(m*K / S)
    logic [55:0] r4_mk;
    logic [31:0] r4_s;
    t_fr_side    r4_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_mk     <= 56'(d2_rem) * 56'(K_HG);
            r4_s      <= d2_side.s;
            r4_side.q <= d2_quo;
            r4_side.f <= d2_side.f;
        end
    end

    logic [23:0] d3_quo;
    logic [31:0] d3_rem;
    t_fr_side    d3_side;

    hgpe_udiv #(.NW(DIV3_STAGES), .DW(32), .SW($bits(t_fr_side))) u_div_f (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rem  (r4_mk[55:24]),
        .i_num  (r4_mk[23:0]),
        .i_den  (r4_s),
        .i_side (r4_side),
        .o_quo  (d3_quo),
        .o_rem  (d3_rem),
        .o_side (d3_side)
    );

    // v = q*K + frac, then special cases and saturation
    logic [33:0] v_sum;
    logic [31:0] n_val;
    logic [31:0] r_val;

    assign v_sum = 34'(d3_side.q) * 34'(K_HG) + 34'(d3_quo);

    always_comb begin
        priority if (d3_side.f.n_zero) begin
            n_val = '0;
        end else if (d3_side.f.t_bad || d3_side.f.q_sat || (v_sum[33:32] != 2'b00)) begin
            n_val = SAT32;
        end else begin
            n_val = v_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;
endmodule

>>> rtl/core/henyey_greenstein_phase_eval.sv
// Henyey-Greenstein phase evaluator, three color channels, APB asymmetry registers.
// Throughput one item per cycle while the output is not stalled.
// Depth is set by the per-channel square root (32 stages) and the three restoring
// dividers (64 + 9 + 24 stages); the whole pipeline holds while the output item waits.
// Reset (i_rst_n, synchronous, active low) empties the pipeline and clears g to zero.
// Depends on hgpe_pkg, hgpe_if and hgpe_chan.
module henyey_greenstein_phase_eval import hgpe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hgpe_in_if.sink            i_in_ch,
    hgpe_out_if.source         o_out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [15:0] r_g_red;
    logic signed [15:0] r_g_green;
    logic signed [15:0] r_g_blue;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_red   <= '0;
            r_g_green <= '0;
            r_g_blue  <= '0;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_G_RED:   r_g_red   <= pwdata[15:0];
                REG_G_GREEN: r_g_green <= pwdata[15:0];
                REG_G_BLUE:  r_g_blue  <= pwdata[15:0];
                default: ;  // drop writes past the register map
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_G_RED:   prdata = {16'b0, r_g_red};
            REG_G_GREEN: prdata = {16'b0, r_g_green};
            REG_G_BLUE:  prdata = {16'b0, r_g_blue};
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline control: one enable for every stage. Advance whenever the
    // output register is empty or being taken; otherwise hold everything.
    // ---------------------------------------------------------------
    logic               en;
    logic               in_acc;
    logic [TOP_LAT-1:0] r_vld;

    assign en             = !r_vld[TOP_LAT-1] || o_out_ch.ready;
    assign i_in_ch.ready  = en;
    assign in_acc         = i_in_ch.valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOP_LAT-2:0], in_acc};
        end
    end

    // ---------------------------------------------------------------
    // Cosine: three products, then their sum (exact, Q.30, up to 3.0)
    // ---------------------------------------------------------------
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_pz;
    logic signed [33:0] r_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= i_in_ch.v_x * i_in_ch.l_x;
            r_py <= i_in_ch.v_y * i_in_ch.l_y;
            r_pz <= i_in_ch.v_z * i_in_ch.l_z;
            r_c  <= 34'(r_px) + 34'(r_py) + 34'(r_pz);
        end
    end

    // ---------------------------------------------------------------
    // Per-channel evaluation
    // ---------------------------------------------------------------
    logic signed [15:0] g_sel  [3];
    logic [31:0]        ch_val [3];

    assign g_sel[0] = r_g_red;
    assign g_sel[1] = r_g_green;
    assign g_sel[2] = r_g_blue;

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        hgpe_chan u_chan (
            .i_clk (i_clk),
            .i_en  (en),
            .i_g   (g_sel[ch]),
            .i_c   (r_c),
            .o_val (ch_val[ch])
        );
    end

    // ---------------------------------------------------------------
    // pdf = floor(sum / 3) by reciprocal multiply; zero pdf forces all to zero
    // ---------------------------------------------------------------
    logic [31:0] r_a1 [3];
    logic [31:0] r_a2 [3];
    logic [33:0] r_sum;
    logic [67:0] r_prod;
    logic [32:0] pdf;
    logic        pdf_nil;

    logic [31:0] r_o_red;
    logic [31:0] r_o_green;
    logic [31:0] r_o_blue;
    logic [31:0] r_o_pdf;
    logic        r_o_zero;

    assign pdf     = r_prod[67:RECIP3_SHIFT];
    assign pdf_nil = (pdf == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1      <= ch_val;
            r_sum     <= 34'(ch_val[0]) + 34'(ch_val[1]) + 34'(ch_val[2]);
            r_a2      <= r_a1;
            r_prod    <= 68'(r_sum) * 68'(RECIP3);
            r_o_red   <= pdf_nil ? '0 : r_a2[0];
            r_o_green <= pdf_nil ? '0 : r_a2[1];
            r_o_blue  <= pdf_nil ? '0 : r_a2[2];
            r_o_pdf   <= pdf_nil ? '0 : pdf[31:0];
            r_o_zero  <= pdf_nil;
        end
    end

    assign o_out_ch.valid       = r_vld[TOP_LAT-1];
    assign o_out_ch.atten_red   = r_o_red;
    assign o_out_ch.atten_green = r_o_green;
    assign o_out_ch.atten_blue  = r_o_blue;
    assign o_out_ch.pdf_value   = r_o_pdf;
    assign o_out_ch.pdf_zero    = r_o_zero;

`ifndef SYNTH
    // a zero pdf item carries only zero values
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && o_out_ch.pdf_zero |->
            (o_out_ch.atten_red == '0) && (o_out_ch.atten_green == '0) &&
            (o_out_ch.atten_blue == '0) && (o_out_ch.pdf_value == '0))
        else $error("pdf_zero item with nonzero values");

    // a nonzero flag-free item has a nonzero pdf
    a_pdf_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && !o_out_ch.pdf_zero |-> (o_out_ch.pdf_value != '0))
        else $error("pdf_value zero without pdf_zero");

    // a stall freezes the valid chain
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid chain moved during stall");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ch.valid && i_in_ch.ready |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");
`endif
endmodule

>>> tb/testbench.sv
// Self-checking bench for the three-channel Henyey-Greenstein phase evaluator.
// Needs hgpe_pkg, hgpe_if and the henyey_greenstein_phase_eval RTL; reads nothing else.
`timescale 1ns / 1ps
module testbench;
    import hgpe_pkg::*;

    typedef struct packed {
        logic signed [15:0] vx, vy, vz, lx, ly, lz;
    } t_dirs;

    typedef struct packed {
        logic [31:0] red, green, blue, pdf;
        logic        zero;
    } t_phase;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 160;     // longer than the pipeline depth TOP_LAT
    localparam int  N_PHASES     = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    hgpe_in_if  in_ch();
    hgpe_out_if out_ch();

    henyey_greenstein_phase_eval DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (in_ch.sink),
        .o_out_ch(out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Bench copy of the asymmetry registers, updated with each APB write inside the map
    logic signed [15:0] g_cfg [3];
    t_dirs  dirs_pending [$];
    t_phase phase_expected [$];
    int     idle_mode;          // 0 none, 1 sender, 2 receiver, 3 both
    logic   taken;
    int     mismatches;
    int     cycles;

    // Fixed-point phase value of one channel: floor arithmetic throughout,
    // saturated to all ones.
    function automatic logic [31:0] hg_channel(longint g, longint c);
        longint            n, t;
        longint unsigned   r, s, q, m, v, x, b;
        n = (longint'(1) <<< 30) - g * g;
        t = (longint'(1) <<< 45) + g * g * 32768 + 2 * g * c;
        if (n <= 0) return '0;          // g of exactly minus one
        if (t <= 0) return SAT32;       // base not positive
        r = (unsigned'(n) << 33) / unsigned'(t);
        x = unsigned'(t) << 14;
        s = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= s + b) begin
                x = x - (s + b);
                s = (s >> 1) + b;
            end else begin
                s = s >> 1;
            end
            b = b >> 2;
        end
        if (s == 0) return SAT32;
        q = r / s;
        m = r % s;
        if (q > 64'hFFFF_FFFF / 64'(K_HG)) return SAT32;
        v = q * 64'(K_HG) + (m * 64'(K_HG)) / s;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    function automatic t_phase hg_predict(t_dirs d);
        longint     c;
        logic [33:0] sum;
        t_phase     p;
        c = longint'(d.vx) * longint'(d.lx) + longint'(d.vy) * longint'(d.ly)
          + longint'(d.vz) * longint'(d.lz);
        p.red   = hg_channel(longint'(g_cfg[REG_G_RED]), c);
        p.green = hg_channel(longint'(g_cfg[REG_G_GREEN]), c);
        p.blue  = hg_channel(longint'(g_cfg[REG_G_BLUE]), c);
        sum = 34'(p.red) + 34'(p.green) + 34'(p.blue);
        p.pdf  = 32'(sum / 3);
        p.zero = (p.pdf == 0);
        if (p.zero) begin
            p.red = '0; p.green = '0; p.blue = '0;
        end
        return p;
    endfunction

    // Note each taken item and queue its predicted result; the driver below holds it until taken.
    always @(posedge i_clk) begin
        taken <= in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            phase_expected.push_back(hg_predict({in_ch.v_x, in_ch.v_y, in_ch.v_z,
                                                 in_ch.l_x, in_ch.l_y, in_ch.l_z}));
    end

    initial begin
        in_ch.valid = 1'b0;
        {in_ch.v_x, in_ch.v_y, in_ch.v_z, in_ch.l_x, in_ch.l_y, in_ch.l_z} = '0;
        out_ch.ready = 1'b0;
        taken = 1'b0;
    end

    always @(negedge i_clk) begin
        t_dirs d;
        int    pct;
        pct = (idle_mode == 3) ? 17 : 74;
        if (i_rst_n && (!in_ch.valid || taken)) begin
            if (dirs_pending.size() > 0 &&
                !(idle_mode[0] && $urandom_range(99) < pct)) begin
                d = dirs_pending.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.v_x <= d.vx; in_ch.v_y <= d.vy; in_ch.v_z <= d.vz;
                in_ch.l_x <= d.lx; in_ch.l_y <= d.ly; in_ch.l_z <= d.lz;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        // receiver stalls
        out_ch.ready <= i_rst_n && !(idle_mode[1] && $urandom_range(99) < pct);
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_phase want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.atten_red, out_ch.atten_green, out_ch.atten_blue,
                   out_ch.pdf_value, out_ch.pdf_zero};
            if (phase_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end else begin
                want = phase_expected.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp r=%h g=%h b=%h pdf=%h z=%b,",
                                  " got r=%h g=%h b=%h pdf=%h z=%b"},
                                 want.red, want.green, want.blue, want.pdf, want.zero,
                                 got.red, got.green, got.blue, got.pdf, got.zero);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle; register takes it at that edge.
    task automatic apb_write(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {{16{val[15]}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx <= REG_G_BLUE) g_cfg[idx] = val;
    endtask

    // Let the last item settle on the bus before checking that nothing is left
    task automatic wait_idle();
        wait (dirs_pending.size() == 0);
        @(posedge i_clk);
        wait (!in_ch.valid && phase_expected.size() == 0);
    endtask

    function automatic logic [15:0] rand_comp(int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(32767)) >>> $urandom_range(15);
            default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    task automatic queue_random(int count);
        t_dirs d;
        int    kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(9);
            d.vx = rand_comp(kind % 3); d.vy = rand_comp(kind % 3);
            d.vz = rand_comp(kind % 3);
            case ($urandom_range(3))
                0: {d.lx, d.ly, d.lz} = {d.vx, d.vy, d.vz};      // forward scatter
                1: {d.lx, d.ly, d.lz} = {-d.vx, -d.vy, -d.vz};   // back scatter
                default: begin
                    d.lx = rand_comp(kind % 3); d.ly = rand_comp(kind % 3);
                    d.lz = rand_comp(kind % 3);
                end
            endcase
            dirs_pending.push_back(d);
        end
    endtask

    initial begin
        logic [15:0] g_set [N_PHASES][3];
        g_set[0] = '{16'h0000, 16'h0000, 16'h0000};
        g_set[1] = '{16'h7FFF, 16'h8001, 16'h4000};
        g_set[2] = '{16'h8000, 16'h8000, 16'h8000};   // g of minus one: pdf zero
        g_set[3] = '{16'h8001, 16'h7FFF, 16'h8000};
        g_set[4] = '{16'h6666, 16'hE000, 16'h0CCD};
        g_set[5] = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
        g_set[6] = '{16'($urandom), 16'($urandom), 16'($urandom)};
        g_set[7] = '{16'($urandom), 16'h0001, 16'hFFFF};

        g_cfg = '{default: '0};
        idle_mode = 0;
        mismatches = 0;
        cycles = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under reset config (g = 0 everywhere)
        dirs_pending.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        dirs_pending.push_back('{16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000});
        dirs_pending.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
        dirs_pending.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000});
        dirs_pending.push_back('{16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001});
        wait_idle();

        for (int ph = 1; ph < N_PHASES; ph++) begin
            for (int r = 0; r < 3; r++) apb_write(2'(r), g_set[ph][r]);
            if (ph == 4) apb_write(2'd3, 16'h7FFF);    // beyond the map: ignored
            idle_mode = ph % 4;
            // Directed: saturating base, tiny value, opposite and aligned extremes
            dirs_pending.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF,
                                     16'h8000, 16'h8000, 16'h8000});
            dirs_pending.push_back('{16'h8000, 16'h8000, 16'h8000,
                                     16'h8000, 16'h8000, 16'h8000});
            dirs_pending.push_back('{16'h7FFF, 16'h0000, 16'h0000,
                                     16'h8001, 16'h0000, 16'h0000});
            queue_random(145);
            wait_idle();
        end

        // Drain and settle
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && phase_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
